[rtl/core/kths_pkg.sv]
// kths_pkg: shared widths, sizes and types for the kth-largest stream tracker.
// No dependencies; imported by the interfaces, the cell and the top level.
package kths_pkg;

    localparam int MAX_K   = 16;
    localparam int VAL_W   = 32;
    localparam int KEEP_W  = 5;
    localparam int CNT_W   = $clog2(MAX_K + 1);

    localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(1);

    typedef logic signed [VAL_W-1:0] t_value;
    typedef logic [KEEP_W-1:0]       t_keep;
    typedef logic [CNT_W-1:0]        t_count;

    // What one cell hands to its lower neighbor.
    typedef struct packed {
        logic   valid;
        logic   ge;
        t_value value;
    } t_link;

    // Next-state view of a cell, used to pick the result.
    typedef struct packed {
        logic   valid;
        t_value value;
    } t_slot;

endpackage

[rtl/core/kths_if.sv]
// kths_if: valid/ready channels for item, result and configuration beats.
// Depends on kths_pkg.
interface kths_item_if;
    import kths_pkg::*;
    logic   valid;
    logic   ready;
    t_value value;
    logic   last;
    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface kths_result_if;
    import kths_pkg::*;
    logic   valid;
    logic   ready;
    t_value kth_value;
    logic   found;
    modport source (output valid, output kth_value, output found, input ready);
    modport sink   (input valid, input kth_value, input found, output ready);
endinterface

interface kths_cfg_if;
    import kths_pkg::*;
    logic  valid;
    logic  ready;
    t_keep data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/kth_largest_stream_tracker.sv]
// kth_largest_stream_tracker: keeps the k largest values of a set in a sorted cell chain.
// The result of a last beat is registered and valid in the cycle after that beat is accepted.
// Throughput: one item per cycle; each accepted beat shifts the chain once.
// An item stalls only while a result waits and the sink is not ready.
// Reset: chain empty, no pending result, r_keep = 1. No clearing pass.
module kth_largest_stream_tracker (
    input  logic i_clk,
    input  logic i_rst_n,
    kths_item_if.sink     i_item,
    kths_result_if.source o_result,
    kths_cfg_if.sink      i_cfg
);
    import kths_pkg::*;

    t_keep  r_keep;
    t_count k_eff;
    logic   accept;
    logic   clear;
    logic   r_out_valid;
    t_value r_out_value;
    logic   r_out_found;
    t_value sel_value;
    logic   sel_found;

    t_link link [MAX_K+1];
    t_slot slot [MAX_K];
    logic  tail [MAX_K];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= KEEP_RESET;
        end else if (i_cfg.valid) begin
            r_keep <= i_cfg.data;
        end
    end

    always_comb begin
        if (r_keep == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(r_keep) > MAX_K) begin
            k_eff = CNT_W'(MAX_K);
        end else begin
            k_eff = CNT_W'(r_keep);
        end
    end

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign accept       = i_item.valid && i_item.ready;
    assign clear        = accept && i_item.last;

    // virtual +inf above the first cell
    assign link[0] = '{valid: 1'b1, ge: 1'b1, value: '0};

    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        kths_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_upd      (accept),
            .i_clear    (clear),
            .i_in_range (CNT_W'(g) < k_eff),
            .i_value    (i_item.value),
            .i_prev     (link[g]),
            .o_link     (link[g+1]),
            .o_next     (slot[g])
        );
        if (g == MAX_K - 1) begin : g_end
            assign tail[g] = slot[g].valid;
        end else begin : g_mid
            assign tail[g] = slot[g].valid && !slot[g+1].valid;
        end
    end

    always_comb begin
        sel_value = '0;
        sel_found = 1'b0;
        for (int i = 0; i < MAX_K; i++) begin
            sel_value = sel_value | (tail[i] ? slot[i].value : '0);
            sel_found = sel_found | slot[i].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (clear) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (clear) begin
            r_out_value <= sel_value;
            r_out_found <= sel_found;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.kth_value = r_out_value;
    assign o_result.found     = r_out_found;

endmodule

[rtl/core/kths_cell.sv]
// kths_cell: one slot of the sorted insertion chain, largest values upstream.
// Depends on kths_pkg.
module kths_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_upd,
    input  logic           i_clear,
    input  logic           i_in_range,
    input  kths_pkg::t_value i_value,
    input  kths_pkg::t_link  i_prev,
    output kths_pkg::t_link  o_link,
    output kths_pkg::t_slot  o_next
);
    import kths_pkg::*;

    logic   r_valid;
    t_value r_value;
    logic   n_valid;
    t_value n_value;
    logic   eff;
    logic   ge;

    always_comb begin
        eff = r_valid && i_in_range;
        ge  = eff && (r_value >= i_value);
        if (ge) begin
            n_valid = 1'b1;
            n_value = r_value;
        end else if (i_prev.ge) begin
            n_valid = 1'b1;
            n_value = i_value;
        end else begin
            n_valid = i_prev.valid;
            n_value = i_prev.value;
        end
        n_valid = n_valid && i_in_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_upd) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd) begin
            r_value <= n_value;
        end
    end

    assign o_link = '{valid: eff, ge: ge, value: r_value};
    assign o_next = '{valid: n_valid, value: n_value};

endmodule

[tb/sv/kth_largest_stream_tracker_tb.sv]
`timescale 1ns / 100ps
// kth_largest_stream_tracker_tb: self-checking bench for the kth-largest tracker.
// Keeps its own sorted keep list per set and checks every result beat against it.
// Depends on kths_pkg, the kths_*_if interfaces and kth_largest_stream_tracker.
module kth_largest_stream_tracker_tb;
    import kths_pkg::*;

    typedef struct {
        t_value kth_value;
        logic   found;
    } t_kth_answer;

    typedef enum int {VAL_FULL, VAL_NARROW, VAL_EDGE} t_value_mix;

    localparam int     DRAIN_CYCLES = 4;
    localparam t_value VAL_MIN      = {1'b1, {(VAL_W-1){1'b0}}};
    localparam t_value VAL_MAX      = {1'b0, {(VAL_W-1){1'b1}}};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kths_item_if   item_ch();
    kths_result_if result_ch();
    kths_cfg_if    cfg_ch();

    kth_largest_stream_tracker u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    t_keep       keep_reg = KEEP_RESET;
    t_value      kept_list [MAX_K];
    int unsigned held_cnt = 0;
    t_kth_answer kth_answers [$];
    int          mismatch_count = 0;
    int unsigned items_sent = 0;
    bit          tx_gaps_on = 1'b0;
    bit          rx_stalls_on = 1'b0;
    int unsigned hold_cycles = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int unsigned keep_depth(t_keep r);
        if (r == '0) return 1;
        if (int'(r) > MAX_K) return MAX_K;
        return 32'(r);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 6);
        return $urandom_range(15, 40);
    endfunction

    function automatic t_keep pick_keep();
        if ($urandom_range(0, 9) < 8) return t_keep'($urandom_range(1, MAX_K));
        return t_keep'($urandom_range(0, 31));
    endfunction

    function automatic t_value pick_value(t_value_mix mix);
        t_value off;
        off = t_value'($urandom_range(0, 2));
        case (mix)
            VAL_NARROW: return t_value'($urandom_range(0, 15)) - t_value'(8);
            VAL_EDGE: begin
                if ($urandom_range(0, 1) == 1) return VAL_MAX - off;
                return VAL_MIN + off;
            end
            default: return t_value'($urandom);
        endcase
    endfunction

    // Insert one value into the keep list; a last beat yields the set's answer.
    function automatic void track_value(t_value v, logic is_last);
        int unsigned k;
        int unsigned pos;
        t_kth_answer ans;
        k = keep_depth(keep_reg);
        if (held_cnt > k) held_cnt = k;
        if (!(held_cnt == k && v <= kept_list[k-1])) begin
            if (held_cnt == k) held_cnt = k - 1;
            pos = 0;
            while (pos < held_cnt && kept_list[pos] >= v) pos++;
            for (int unsigned i = held_cnt; i > pos; i--) kept_list[i] = kept_list[i-1];
            kept_list[pos] = v;
            held_cnt++;
        end
        if (is_last) begin
            ans.found = (held_cnt > 0);
            if (held_cnt > 0) begin
                ans.kth_value = kept_list[held_cnt-1];
            end else begin
                ans.kth_value = '0;
            end
            kth_answers.insert(kth_answers.size(), ans);
            held_cnt = 0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic send_item(t_value v, logic is_last);
        int unsigned gap;
        gap = 0;
        if (tx_gaps_on && $urandom_range(0, 2) == 0) gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= is_last;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        track_value(v, is_last);
        items_sent++;
    endtask

    task automatic send_set(int unsigned len, t_value_mix mix);
        for (int unsigned i = 0; i < len; i++) send_item(pick_value(mix), i == len - 1);
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (kth_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_keep(t_keep k);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= k;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        keep_reg = k;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // k from reset, extremes of the value range, single-beat set
    task automatic test_reset_keep();
        send_item(-5, 1'b0);
        send_item(3, 1'b0);
        send_item(VAL_MIN, 1'b1);
        send_item(VAL_MAX, 1'b1);
        wait_drain();
    endtask

    // k of zero acts as one, k above the store saturates
    task automatic test_keep_limits();
        write_keep(t_keep'(0));
        send_item(10, 1'b0);
        send_item(-1, 1'b0);
        send_item(10, 1'b1);
        wait_drain();
        write_keep(t_keep'(31));
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MAX, 1'b0);
        send_item(0, 1'b1);
        wait_drain();
    endtask

    // value equal to the tail of a full list
    task automatic test_equal_tail();
        write_keep(t_keep'(2));
        send_item(9, 1'b0);
        send_item(7, 1'b0);
        send_item(7, 1'b1);
        wait_drain();
    endtask

    // k lowered in mid-set trims the list at the next beat
    task automatic test_keep_lowered();
        write_keep(t_keep'(4));
        send_item(40, 1'b0);
        send_item(30, 1'b0);
        send_item(20, 1'b0);
        send_item(10, 1'b0);
        wait_drain();
        write_keep(t_keep'(2));
        send_item(5, 1'b1);
        wait_drain();
        write_keep(t_keep'(MAX_K));
    endtask

    task automatic test_random_sets(int unsigned item_goal);
        int unsigned stop_at;
        int unsigned len;
        int unsigned cut;
        t_value_mix  mix;
        stop_at = items_sent + item_goal;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_drain();
                write_keep(pick_keep());
            end
            if ($urandom_range(0, 7) == 0) begin
                tx_gaps_on   = ($urandom_range(0, 3) != 0);
                rx_stalls_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 8) begin
                len = $urandom_range(1, keep_depth(keep_reg) + 3);
            end else begin
                len = $urandom_range(1, 40);
            end
            mix = t_value_mix'($urandom_range(0, 2));
            if (len > 1 && $urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, len - 1);
                for (int unsigned i = 0; i < cut; i++) send_item(pick_value(mix), 1'b0);
                wait_drain();
                write_keep(pick_keep());
                for (int unsigned i = cut; i < len; i++) begin
                    send_item(pick_value(mix), i == len - 1);
                end
            end else begin
                send_set(len, mix);
            end
        end
    endtask

    // sink held off while beats keep coming, then a full drain, then narrow sets with gaps and stalls
    task automatic test_backpressure();
        wait_drain();
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        @(posedge i_clk);
        hold_cycles = 80;
        repeat (15) send_set($urandom_range(1, 3), VAL_FULL);
        wait_drain();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        repeat (5) send_set($urandom_range(1, 3), VAL_NARROW);
        wait_drain();
    endtask

    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                result_ch.ready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                result_ch.ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_kth_answer want;
        if (i_rst_n && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (kth_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected beat kth_value=%0d found=%0b",
                                          result_ch.kth_value, result_ch.found));
            end else begin
                want = kth_answers.pop_front();
                if (result_ch.found !== want.found) begin
                    report_mismatch($sformatf("found %0b, want %0b",
                                              result_ch.found, want.found));
                end
                if (result_ch.kth_value !== want.kth_value) begin
                    report_mismatch($sformatf("kth_value %0d, want %0d",
                                              result_ch.kth_value, want.kth_value));
                end
            end
        end
    end

    initial begin : run_limit
        #5000000;
        $display("tb: failure");
        $finish;
    end

    initial begin : main_flow
        item_ch.valid   = 1'b0;
        item_ch.value   = '0;
        item_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_keep();
        test_keep_limits();
        test_equal_tail();
        test_keep_lowered();
        test_random_sets(540);
        test_backpressure();
        wait_drain();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[kth_largest_stream_tracker.f]
rtl/core/kths_pkg.sv
rtl/core/kths_if.sv
rtl/core/kths_cell.sv
rtl/core/kth_largest_stream_tracker.sv
tb/sv/kth_largest_stream_tracker_tb.sv
